// ----- design/encoder_delta_velocity_defines.svh -----
// Assertion macros shared by the encoder velocity block.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ENCODER_DELTA_VELOCITY_DEFINES_SVH
`define ENCODER_DELTA_VELOCITY_DEFINES_SVH

`ifndef SYNTHESIS

`define EDV_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

`define EDV_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define EDV_ASSERT(lbl, expr, msg)

`define EDV_NEVER(lbl, expr, msg)

`endif

`endif

// ----- design/edv_pkg.sv -----
package edv_pkg;

  localparam int unsigned NUM_WHEELS_DEF = 4;

  localparam int unsigned WHEEL_W    = 2;
  localparam int unsigned PPR_W      = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DELTA_W    = 33;
  localparam int unsigned DISP_W     = 48;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 1'd1;

  localparam logic [PPR_W-1:0] PPR_RESET    = 16'd1550;
  localparam logic [CNT_W-1:0] RELOAD_RESET = 32'd65535;

  // 2*pi scaled by 2^29 and rounded.
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  localparam logic [DISP_W-1:0] DISP_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [DISP_W-1:0] DISP_MIN = 48'h8000_0000_0000;
  localparam logic [VEL_W-1:0]  VEL_MAX  = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0]  VEL_MIN  = 32'h8000_0000;

  // Digit-serial multiplier: 32-bit operand consumed a few bits per cycle.
  localparam int unsigned MUL_OP_W    = 32;
  localparam int unsigned MUL_PROD_W  = 64;
  localparam int unsigned MUL_DIGIT_W = 4;
  localparam int unsigned MUL_STEPS   = MUL_OP_W / MUL_DIGIT_W;
  localparam int unsigned MUL_CNT_W   = $clog2(MUL_STEPS + 1);

  // Bit-serial restoring divider.
  localparam int unsigned DIV_REM_W = 32;
  localparam int unsigned DIV_DVD_W = 64;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned STEP_W    = 51;
  localparam logic [DIV_CNT_W-1:0] DIV_ANGLE_STEPS = 7'd51;
  localparam logic [DIV_CNT_W-1:0] DIV_VEL_STEPS   = 7'd32;

  localparam int unsigned SCL_W = 62;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DELTA,
    S_MAG,
    S_MUL,
    S_ROUND,
    S_DIV_ANGLE,
    S_DISP,
    S_SCALE24,
    S_SCALE1000,
    S_ADD_HALF,
    S_VEL_CHK,
    S_DIV_VEL,
    S_FINISH
  } edv_state_t;

endpackage

// ----- design/edv_in_if.sv -----
interface edv_in_if import edv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [WHEEL_W-1:0] wheel;
  logic [CNT_W-1:0]   counter_value;
  logic               counting_down;
  logic [TIME_W-1:0]  now_ms;

  modport source (
    output valid, mode, wheel, counter_value, counting_down, now_ms,
    input  ready
  );

  modport sink (
    input  valid, mode, wheel, counter_value, counting_down, now_ms,
    output ready
  );
endinterface

// ----- design/edv_out_if.sv -----
interface edv_out_if import edv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [WHEEL_W-1:0]        wheel_out;
  logic                      updated;
  logic signed [DELTA_W-1:0] pulse_delta;
  logic signed [DISP_W-1:0]  displacement;
  logic signed [VEL_W-1:0]   velocity;

  modport source (
    output valid, wheel_out, updated, pulse_delta, displacement, velocity,
    input  ready
  );

  modport sink (
    input  valid, wheel_out, updated, pulse_delta, displacement, velocity,
    output ready
  );
endinterface

// ----- design/edv_serial_mult.sv -----
module edv_serial_mult import edv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MUL_OP_W-1:0]   operand,
  output logic                  busy,
  output logic [MUL_PROD_W-1:0] product
);

  localparam int unsigned PART_W = MUL_OP_W + MUL_DIGIT_W;

  logic [MUL_OP_W-1:0]  a_r, a_nxt;
  logic [MUL_OP_W-1:0]  hi_r, hi_nxt;
  logic [MUL_OP_W-1:0]  lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [PART_W-1:0]    partial;

  // The constant is multiplied by one digit of the operand per cycle. The
  // low digit of each partial sum retires into lo_r, so after the last digit
  // {hi_r, lo_r} is the full product.
  always_comb begin
    partial = {{MUL_DIGIT_W{1'b0}}, hi_r}
            + PART_W'(TWO_PI_Q29) * PART_W'(a_r[MUL_DIGIT_W-1:0]);
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = operand;
      hi_nxt   = '0;
      lo_nxt   = '0;
      cnt_nxt  = MUL_CNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt    = a_r >> MUL_DIGIT_W;
      hi_nxt   = partial[PART_W-1:MUL_DIGIT_W];
      lo_nxt   = {partial[MUL_DIGIT_W-1:0], lo_r[MUL_OP_W-1:MUL_DIGIT_W]};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign busy    = busy_r;
  assign product = {hi_r, lo_r};

endmodule

// ----- design/edv_serial_div.sv -----
`include "encoder_delta_velocity_defines.svh"

module edv_serial_div import edv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  input  logic [DIV_REM_W-1:0] rem_init,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_REM_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_REM_W-1:0] div_r, div_nxt;
  logic [DIV_DVD_W-1:0] sh_r, sh_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIV_REM_W:0]   trial;
  logic [DIV_REM_W:0]   diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle. Dividend bits leave the
  // top of sh_r while quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem_r, sh_r[DIV_DVD_W-1]};
    diff     = trial - {1'b0, div_r};
    ge       = (trial >= {1'b0, div_r});
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = rem_init;
      div_nxt  = divisor;
      sh_nxt   = dividend;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      sh_nxt   = {sh_r[DIV_DVD_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy     = busy_r;
  assign quotient = sh_r;

  `EDV_ASSERT(a_div_rem_below, busy_r |-> (rem_r < div_r), "divider remainder reached divisor")

endmodule

// ----- design/encoder_delta_velocity.sv -----
// Encoder velocity tracker for up to NUM_WHEELS wheels.
// Input channel in_ch carries one word per sample: mode (0 update, 1 clear),
// wheel index, timer counter snapshot, direction flag and a ms timestamp.
// Result channel out_ch returns exactly one word per input word: the wheel,
// an updated flag, the signed pulse delta, the saturated Q32.16 displacement
// and the saturated Q16.16 velocity of that wheel.
// Configuration is written through cfg_we/cfg_index/cfg_data: index 0 is
// pulses per revolution, index 1 the timer auto-reload value. The user must
// write it only while idle; the block itself does not enforce this.
// An update word passes the 4-bit digit-serial multiplier, then the shared
// bit-serial divider for the angle step and again for the velocity, which is
// skipped when the velocity saturates. Clear words and unknown wheels go from
// S_DIFF straight to S_FINISH, skipped updates by way of S_DELTA.
// One word is in flight at a time; in_ch.ready is high only while idle, so
// the next word can be taken as soon as the result is registered.
// The result sits in an output register, so a new word is taken while it
// waits; a finished word then holds in its last step until out_ch.ready.
// Reset (synchronous, rst_n low) zeroes all wheel state and restores the
// configuration defaults; no clearing pass is needed afterwards.
`include "encoder_delta_velocity_defines.svh"

module encoder_delta_velocity import edv_pkg::*; #(
  parameter int unsigned NUM_WHEELS = NUM_WHEELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  edv_in_if.sink                in_ch,
  edv_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned WIDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam logic [4:0]  NW_LIMIT = 5'(NUM_WHEELS);

  edv_state_t state_r, state_nxt;

  logic [PPR_W-1:0] ppr_r;
  logic [CNT_W-1:0] reload_r;

  logic [CNT_W-1:0]  last_cnt_r  [NUM_WHEELS];
  logic [TIME_W-1:0] last_time_r [NUM_WHEELS];
  logic [DISP_W-1:0] accum_r     [NUM_WHEELS];
  logic [VEL_W-1:0]  speed_r     [NUM_WHEELS];

  logic               mode_r, mode_nxt;
  logic [WHEEL_W-1:0] wheel_r, wheel_nxt;
  logic [CNT_W-1:0]   cv_r, cv_nxt;
  logic               down_r, down_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [CNT_W-1:0]   ad_r, ad_nxt;
  logic               gt_r, gt_nxt;
  logic               eq_r, eq_nxt;
  logic [TIME_W-1:0]  dur_r, dur_nxt;
  logic               upd_r, upd_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [STEP_W-1:0]  mag_r, mag_nxt;
  logic [DISP_W-1:0]  disp_r, disp_nxt;
  logic [SCL_W-1:0]   scl_r, scl_nxt;
  logic [VEL_W-1:0]   vel_r, vel_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [WHEEL_W-1:0] out_wheel_r, out_wheel_nxt;
  logic               out_upd_r, out_upd_nxt;
  logic [DELTA_W-1:0] out_delta_r, out_delta_nxt;
  logic [DISP_W-1:0]  out_disp_r, out_disp_nxt;
  logic [VEL_W-1:0]   out_vel_r, out_vel_nxt;

  logic [WIDX_W-1:0]  widx;
  logic               wvalid;
  logic [CNT_W-1:0]   rd_cnt;
  logic [TIME_W-1:0]  rd_time;
  logic [DISP_W-1:0]  rd_acc;
  logic [VEL_W-1:0]   rd_spd;
  logic [PPR_W-1:0]   ppr_eff;
  logic               neg;
  logic [DELTA_W-1:0] delta_neg;
  logic [MUL_OP_W-1:0] mag32;
  logic [MUL_PROD_W-1:0] rsum;
  logic [STEP_W:0]    step;
  logic [DISP_W+4:0]  dsum;
  logic               vsat;
  logic [VEL_W-1:0]   vq;
  logic [VEL_W-1:0]   vmag;
  logic [VEL_W-1:0]   vel_fin;
  logic               load;
  logic               st_we;
  logic               st_clr;

  logic                  mul_start;
  logic                  mul_busy;
  logic [MUL_PROD_W-1:0] mul_prod;
  div_req_t              div_req;
  logic [DIV_REM_W-1:0]  div_rem_init;
  logic [DIV_DVD_W-1:0]  div_dividend;
  logic [DIV_REM_W-1:0]  div_divisor;
  logic                  div_busy;
  logic [DIV_DVD_W-1:0]  div_quot;

  edv_serial_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mag32),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  edv_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign widx    = WIDX_W'(wheel_r);
  assign wvalid  = ({3'b000, wheel_r} < NW_LIMIT);
  assign rd_cnt  = last_cnt_r[widx];
  assign rd_time = last_time_r[widx];
  assign rd_acc  = accum_r[widx];
  assign rd_spd  = speed_r[widx];
  assign ppr_eff = (ppr_r == '0) ? PPR_W'(1) : ppr_r;

  always_comb begin
    neg       = delta_r[DELTA_W-1];
    delta_neg = -delta_r;
    mag32     = neg ? delta_neg[MUL_OP_W-1:0] : delta_r[MUL_OP_W-1:0];
    // Rounding offset is half the divisor ppr * 2^13; the 2^13 is a shift.
    rsum      = mul_prod + {36'd0, ppr_eff, 12'd0};
    step      = neg ? -{1'b0, mag_r} : {1'b0, mag_r};
    dsum      = {{5{rd_acc[DISP_W-1]}}, rd_acc} + {step[STEP_W], step};
    // The velocity quotient needs more than 32 bits when the dividend's
    // upper half already reaches the duration.
    vsat      = ({2'b00, scl_r[SCL_W-1:32]} >= dur_r);
    vq        = div_quot[VEL_W-1:0];
    vmag      = (vq > VEL_MIN) ? VEL_MIN : vq;
    if (neg) begin
      vel_fin = -vmag;
    end else begin
      vel_fin = vmag[VEL_W-1] ? VEL_MAX : vmag;
    end
    load = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    wheel_nxt     = wheel_r;
    cv_nxt        = cv_r;
    down_nxt      = down_r;
    now_nxt       = now_r;
    ad_nxt        = ad_r;
    gt_nxt        = gt_r;
    eq_nxt        = eq_r;
    dur_nxt       = dur_r;
    upd_nxt       = upd_r;
    delta_nxt     = delta_r;
    mag_nxt       = mag_r;
    disp_nxt      = disp_r;
    scl_nxt       = scl_r;
    vel_nxt       = vel_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_wheel_nxt = out_wheel_r;
    out_upd_nxt   = out_upd_r;
    out_delta_nxt = out_delta_r;
    out_disp_nxt  = out_disp_r;
    out_vel_nxt   = out_vel_r;
    st_we         = 1'b0;
    st_clr        = 1'b0;
    mul_start     = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = DIV_VEL_STEPS;
    div_rem_init  = {2'b00, scl_r[SCL_W-1:32]};
    div_dividend  = {scl_r[31:0], 32'd0};
    div_divisor   = dur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          wheel_nxt = in_ch.wheel;
          cv_nxt    = in_ch.counter_value;
          down_nxt  = in_ch.counting_down;
          now_nxt   = in_ch.now_ms;
          upd_nxt   = 1'b0;
          delta_nxt = '0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        if (!wvalid || mode_r) begin
          state_nxt = S_FINISH;
        end else begin
          gt_nxt    = (cv_r > rd_cnt);
          eq_nxt    = (cv_r == rd_cnt);
          ad_nxt    = (cv_r > rd_cnt) ? (cv_r - rd_cnt) : (rd_cnt - cv_r);
          dur_nxt   = now_r - rd_time;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        if (dur_r[TIME_W-1:1] == '0) begin
          // Too soon after the last update: the wheel keeps its state.
          state_nxt = S_FINISH;
        end else begin
          upd_nxt = 1'b1;
          if (eq_r) begin
            delta_nxt = '0;
          end else if (gt_r) begin
            delta_nxt = down_r ? ({1'b0, ad_r} - {1'b0, reload_r}) : {1'b0, ad_r};
          end else begin
            delta_nxt = down_r ? -{1'b0, ad_r} : ({1'b0, reload_r} - {1'b0, ad_r});
          end
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (!mul_busy) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        div_req.start = 1'b1;
        div_req.steps = DIV_ANGLE_STEPS;
        div_rem_init  = '0;
        div_dividend  = {rsum[MUL_PROD_W-1:13], 13'd0};
        div_divisor   = {16'd0, ppr_eff};
        state_nxt     = S_DIV_ANGLE;
      end
      S_DIV_ANGLE: begin
        if (!div_busy) begin
          mag_nxt   = div_quot[STEP_W-1:0];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if ((&dsum[DISP_W+4:DISP_W-1]) || (~|dsum[DISP_W+4:DISP_W-1])) begin
          disp_nxt = dsum[DISP_W-1:0];
        end else begin
          disp_nxt = dsum[DISP_W+4] ? DISP_MIN : DISP_MAX;
        end
        state_nxt = S_SCALE24;
      end
      S_SCALE24: begin
        scl_nxt   = SCL_W'({mag_r, 4'd0}) + SCL_W'({mag_r, 3'd0});
        state_nxt = S_SCALE1000;
      end
      S_SCALE1000: begin
        // 1000 = 1024 - 24
        scl_nxt   = SCL_W'({mag_r, 10'd0}) - scl_r;
        state_nxt = S_ADD_HALF;
      end
      S_ADD_HALF: begin
        scl_nxt   = scl_r + {31'd0, dur_r[TIME_W-1:1]};
        state_nxt = S_VEL_CHK;
      end
      S_VEL_CHK: begin
        if (vsat) begin
          vel_nxt   = neg ? VEL_MIN : VEL_MAX;
          state_nxt = S_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV_VEL;
        end
      end
      S_DIV_VEL: begin
        if (!div_busy) begin
          vel_nxt   = vel_fin;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_wheel_nxt = wheel_r;
          out_upd_nxt   = 1'b0;
          out_delta_nxt = '0;
          out_disp_nxt  = '0;
          out_vel_nxt   = '0;
          if (wvalid) begin
            if (mode_r) begin
              st_clr = 1'b1;
            end else if (upd_r) begin
              st_we         = 1'b1;
              out_upd_nxt   = 1'b1;
              out_delta_nxt = delta_r;
              out_disp_nxt  = disp_r;
              out_vel_nxt   = vel_r;
            end else begin
              out_disp_nxt = rd_acc;
              out_vel_nxt  = rd_spd;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    wheel_r     <= wheel_nxt;
    cv_r        <= cv_nxt;
    down_r      <= down_nxt;
    now_r       <= now_nxt;
    ad_r        <= ad_nxt;
    gt_r        <= gt_nxt;
    eq_r        <= eq_nxt;
    dur_r       <= dur_nxt;
    upd_r       <= upd_nxt;
    delta_r     <= delta_nxt;
    mag_r       <= mag_nxt;
    disp_r      <= disp_nxt;
    scl_r       <= scl_nxt;
    vel_r       <= vel_nxt;
    out_wheel_r <= out_wheel_nxt;
    out_upd_r   <= out_upd_nxt;
    out_delta_r <= out_delta_nxt;
    out_disp_r  <= out_disp_nxt;
    out_vel_r   <= out_vel_nxt;
  end

  // A clear keeps the wheel's last update time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_cnt_r[i]  <= '0;
        last_time_r[i] <= '0;
        accum_r[i]     <= '0;
        speed_r[i]     <= '0;
      end
    end else if (st_clr) begin
      last_cnt_r[widx] <= '0;
      accum_r[widx]    <= '0;
      speed_r[widx]    <= '0;
    end else if (st_we) begin
      last_cnt_r[widx]  <= cv_r;
      last_time_r[widx] <= now_r;
      accum_r[widx]     <= disp_r;
      speed_r[widx]     <= vel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r    <= PPR_RESET;
      reload_r <= RELOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PPR:    ppr_r    <= cfg_data[PPR_W-1:0];
        CFG_RELOAD: reload_r <= cfg_data[CNT_W-1:0];
        default:    ppr_r    <= ppr_r;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.wheel_out    = out_wheel_r;
  assign out_ch.updated      = out_upd_r;
  assign out_ch.pulse_delta  = out_delta_r;
  assign out_ch.displacement = out_disp_r;
  assign out_ch.velocity     = out_vel_r;

  `EDV_ASSERT(a_skip_no_delta, (out_valid_r && !out_upd_r) |-> (out_delta_r == '0), "skipped word carries a pulse delta")
  `EDV_NEVER(a_units_overlap, mul_busy && div_busy, "multiplier and divider busy together")
  `EDV_ASSERT(a_vel_sign, (out_valid_r && out_upd_r && (out_vel_r != '0)) |-> (out_vel_r[VEL_W-1] == out_delta_r[DELTA_W-1]), "velocity sign differs from pulse delta sign")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import edv_pkg::*;

  localparam int RAND_PHASES    = 5;
  localparam int WORDS_PER_PHASE = 230;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 120;

  localparam longint ANGLE_HI = longint'($signed(DISP_MAX));
  localparam longint ANGLE_LO = longint'($signed(DISP_MIN));
  localparam longint SPEED_HI = longint'($signed(VEL_MAX));

  typedef struct packed {
    logic               mode;
    logic [WHEEL_W-1:0] wheel;
    logic [CNT_W-1:0]   counter_value;
    logic               counting_down;
    logic [TIME_W-1:0]  now_ms;
  } enc_sample_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic               updated;
    logic [DELTA_W-1:0] delta;
    logic [DISP_W-1:0]  disp;
    logic [VEL_W-1:0]   vel;
  } wheel_result_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    enc_sample_t           smp;
    wheel_result_t         want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  edv_in_if  in_ch ();
  edv_out_if out_ch ();

  encoder_delta_velocity dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's registers and per-wheel state.
  logic [PPR_W-1:0]  ppr_reg    = PPR_RESET;
  logic [CNT_W-1:0]  reload_reg = RELOAD_RESET;
  logic [CNT_W-1:0]  wheel_last_cnt [NUM_WHEELS_DEF] = '{default: '0};
  logic [TIME_W-1:0] wheel_last_ms  [NUM_WHEELS_DEF] = '{default: '0};
  longint            wheel_angle    [NUM_WHEELS_DEF] = '{default: 0};
  logic [VEL_W-1:0]  wheel_speed    [NUM_WHEELS_DEF] = '{default: '0};

  wheel_result_t pending_results [$];
  stim_row_t     stim_rows [$];
  int            fail_cnt = 0;
  int            quiet_cycles = 0;
  bit            calm_in = 1'b0;
  bit            calm_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic wheel_result_t track_wheel(enc_sample_t s);
    wheel_result_t r;
    logic [TIME_W-1:0] dur;
    logic [CNT_W-1:0]  prev;
    bit [63:0]         dvsr, mag, smag;
    longint            dlt, diff, step, acc, spd;
    r = '0;
    r.wheel = s.wheel;
    if (s.wheel < NUM_WHEELS_DEF) begin
      if (s.mode) begin
        wheel_last_cnt[s.wheel] = '0;
        wheel_angle[s.wheel] = 0;
        wheel_speed[s.wheel] = '0;
      end else begin
        dur = s.now_ms - wheel_last_ms[s.wheel];
        if (dur > 1) begin
          prev = wheel_last_cnt[s.wheel];
          dvsr = 64'((ppr_reg == '0) ? 16'd1 : ppr_reg) << 13;
          // Wrap correction uses the reload value as is, without adding one.
          if (s.counter_value == prev) begin
            dlt = 0;
          end else if (s.counter_value > prev) begin
            diff = longint'({32'd0, s.counter_value - prev});
            dlt = s.counting_down ? -(longint'({32'd0, reload_reg}) - diff) : diff;
          end else begin
            diff = longint'({32'd0, prev - s.counter_value});
            dlt = s.counting_down ? -diff : longint'({32'd0, reload_reg}) - diff;
          end
          mag = (dlt < 0) ? 64'(-dlt) : 64'(dlt);
          mag = (mag * TWO_PI_Q29 + (dvsr >> 1)) / dvsr;
          step = (dlt < 0) ? -longint'(mag) : longint'(mag);
          acc = wheel_angle[s.wheel] + step;
          if (acc > ANGLE_HI) acc = ANGLE_HI;
          else if (acc < ANGLE_LO) acc = ANGLE_LO;
          wheel_angle[s.wheel] = acc;
          smag = (mag * 64'd1000 + 64'(dur >> 1)) / 64'(dur);
          if (smag > 64'h8000_0000) smag = 64'h8000_0000;
          spd = (dlt < 0) ? -longint'(smag) : longint'(smag);
          if (spd > SPEED_HI) spd = SPEED_HI;
          wheel_speed[s.wheel] = spd[VEL_W-1:0];
          wheel_last_cnt[s.wheel] = s.counter_value;
          wheel_last_ms[s.wheel] = s.now_ms;
          r.updated = 1'b1;
          r.delta = dlt[DELTA_W-1:0];
        end
      end
      r.disp = wheel_angle[s.wheel][DISP_W-1:0];
      r.vel = wheel_speed[s.wheel];
    end
    return r;
  endfunction

  task automatic tab_word(input logic mode, input logic [WHEEL_W-1:0] wheel,
                          input logic [CNT_W-1:0] cnt, input logic down,
                          input logic [TIME_W-1:0] now);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.smp = '{mode, wheel, cnt, down, now};
    row.want = '0;
    row.reg_idx = '0;
    row.reg_val = '0;
    stim_rows.push_back(row);
  endtask

  // Attaches a hand-written result to the word added last.
  task automatic tab_want(input logic upd, input logic [DELTA_W-1:0] dlt,
                          input logic [DISP_W-1:0] disp, input logic [VEL_W-1:0] vel);
    int k;
    k = stim_rows.size() - 1;
    stim_rows[k].kind = ROW_CHECKED;
    stim_rows[k].want = '{stim_rows[k].smp.wheel, upd, dlt, disp, vel};
  endtask

  task automatic tab_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.smp = '0;
    row.want = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endtask

  task automatic send_word(input enc_sample_t smp, input bit typed, input wheel_result_t want);
    wheel_result_t predicted;
    int gap;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= smp.mode;
    in_ch.wheel <= smp.wheel;
    in_ch.counter_value <= smp.counter_value;
    in_ch.counting_down <= smp.counting_down;
    in_ch.now_ms <= smp.now_ms;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = track_wheel(smp);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The enable stays high across back-to-back writes and drops after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit close_we);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (close_we) cfg_we <= 1'b0;
    if (idx == CFG_PPR) reload_reg = reload_reg;
    if (idx == CFG_PPR) ppr_reg = val[PPR_W-1:0];
    else reload_reg = val;
  endtask

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("encoder_delta_velocity test failed");
      $finish;
    end
  end

  initial begin
    wheel_result_t want;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result word for wheel %0d arrived with nothing expected", out_ch.wheel_out);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.wheel_out !== want.wheel) begin
          $error("wheel_out: expected %0d, got %0d", want.wheel, out_ch.wheel_out);
          fail_cnt++;
        end
        if (out_ch.updated !== want.updated) begin
          $error("updated: expected %0d, got %0d", want.updated, out_ch.updated);
          fail_cnt++;
        end
        if (out_ch.pulse_delta !== want.delta) begin
          $error("pulse_delta: expected %0d, got %0d", $signed(want.delta),
                 out_ch.pulse_delta);
          fail_cnt++;
        end
        if (out_ch.displacement !== want.disp) begin
          $error("displacement: expected %0d, got %0d", $signed(want.disp),
                 out_ch.displacement);
          fail_cnt++;
        end
        if (out_ch.velocity !== want.vel) begin
          $error("velocity: expected %0d, got %0d", $signed(want.vel), out_ch.velocity);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    enc_sample_t       smp;
    wheel_result_t     none;
    int                pick;
    logic [PPR_W-1:0]  ppr_pick;
    logic [CNT_W-1:0]  rl_pick;
    bit [63:0]         span, hop, base;
    bit                close_we;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PPR;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= 1'b0;
    in_ch.wheel <= '0;
    in_ch.counter_value <= '0;
    in_ch.counting_down <= 1'b0;
    in_ch.now_ms <= '0;
    none = '0;

    // Too soon right after reset (zero and one ms), then every wrap case.
    tab_word(0, 0, 0, 0, 0);                      tab_want(0, '0, '0, '0);
    tab_word(0, 0, 100, 0, 1);                    tab_want(0, '0, '0, '0);
    tab_word(0, 0, 100, 0, 2);
    tab_word(0, 0, 50, 0, 10);
    tab_word(0, 0, 20, 1, 20);
    tab_word(0, 0, 1000, 1, 30);
    tab_word(0, 0, 1000, 0, 40);
    tab_word(1, 0, '1, 1, '1);                    tab_want(0, '0, '0, '0);
    tab_word(0, 1, '1, 0, '1);
    tab_word(0, 1, 0, 0, 0);
    tab_word(0, 1, 0, 1, 2);
    // Count difference far above the reload value.
    tab_word(0, 2, '1, 1, 5);
    tab_word(1, 3, 0, 0, 0);                      tab_want(0, '0, '0, '0);
    tab_word(0, 3, 0, 0, 1);                      tab_want(0, '0, '0, '0);
    // One pulse per revolution: a full-range delta saturates both outputs.
    tab_reg(CFG_PPR, 32'hA5A5_0001);
    tab_reg(CFG_RELOAD, '1);
    tab_word(1, 2, 0, 0, 0);                      tab_want(0, '0, '0, '0);
    tab_word(0, 2, '1, 0, 1005);                  tab_want(1, 33'h0_FFFF_FFFF, DISP_MAX, VEL_MAX);
    tab_word(0, 2, 0, 1, 2005);                   tab_want(1, 33'h1_0000_0001, DISP_MIN, VEL_MIN);
    tab_reg(CFG_PPR, 32'h0000_FFFF);
    tab_reg(CFG_RELOAD, 32'd1);
    tab_word(0, 3, 5, 0, 9);
    tab_word(0, 3, 2, 0, 20);
    tab_word(0, 3, 7, 1, 30);
    // A zero pulse count per revolution behaves as one.
    tab_reg(CFG_PPR, 32'h5A5A_0000);
    tab_reg(CFG_RELOAD, 32'd65535);
    tab_word(0, 1, 12, 0, 40);
    tab_word(0, 1, 12, 0, 42);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        close_we = (i + 1 == stim_rows.size()) || (stim_rows[i + 1].kind != ROW_REG);
        drain_results();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val, close_we);
      end else begin
        send_word(stim_rows[i].smp, stim_rows[i].kind == ROW_CHECKED, stim_rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          ppr_pick = PPR_RESET;
          rl_pick = RELOAD_RESET;
        end
        1: begin
          ppr_pick = 16'd1;
          rl_pick = '1;
        end
        2: begin
          ppr_pick = '1;
          rl_pick = 32'd1;
        end
        3: begin
          ppr_pick = '0;
          rl_pick = $urandom;
        end
        default: begin
          ppr_pick = PPR_W'($urandom_range(1, 65535));
          rl_pick = $urandom_range(0, 200000);
        end
      endcase
      drain_results();
      write_reg(CFG_PPR, {16'($urandom), ppr_pick}, 1'b0);
      write_reg(CFG_RELOAD, rl_pick, 1'b1);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        smp.mode = 1'b0;
        smp.wheel = WHEEL_W'($urandom_range(0, NUM_WHEELS_DEF - 1));
        smp.counter_value = $urandom;
        smp.counting_down = 1'(($urandom));
        smp.now_ms = $urandom;
        if (pick < 5) begin
          smp.mode = 1'b1;
        end else if (pick < 15) begin
          // Fully random word: fields are already drawn.
        end else if (pick < 23) begin
          smp.now_ms = wheel_last_ms[smp.wheel] + TIME_W'($urandom_range(0, 1));
        end else begin
          // A plausible next sample: counter moves within the reload range.
          if ($urandom_range(0, 9) == 0) smp.now_ms = wheel_last_ms[smp.wheel] + $urandom;
          else smp.now_ms = wheel_last_ms[smp.wheel] + TIME_W'($urandom_range(2, 40));
          span = {32'd0, reload_reg} + 64'd1;
          base = {32'd0, wheel_last_cnt[smp.wheel]};
          hop = ($urandom_range(0, 7) == 0) ? 64'($urandom) : 64'($urandom_range(0, 600));
          if (smp.counting_down) smp.counter_value = CNT_W'((base + span - (hop % span)) % span);
          else smp.counter_value = CNT_W'((base + hop) % span);
          if ($urandom_range(0, 11) == 0) smp.counting_down = !smp.counting_down;
        end
        send_word(smp, 1'b0, none);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("encoder_delta_velocity test passed");
    end else begin
      $display("encoder_delta_velocity test failed");
    end
    $finish;
  end

endmodule
